// ===== hw/rtl/ppal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ppal_pkg;

    // Default build values
    localparam int MAX_VERTICES_DEF  = 1024;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int SEG_W     = 34;
    localparam int LEN_W     = 44;
    localparam int ROOT_W    = 33;
    localparam int RAD_W     = 66;
    localparam int RATIO_W   = 31;
    localparam int RATIO_BITS = 30;
    localparam int STEP_W    = 6;

    // Iteration counts of the shared units
    localparam logic [STEP_W-1:0] ROOT_STEPS = 6'd33;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 6'd31;

    // Vertex command codes
    localparam logic [1:0] CMD_MOVE = 2'd0;
    localparam logic [1:0] CMD_LINE = 2'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic cap;
        logic diff;
        logic sqr;
        logic sum;
        logic root;
        logic store;
        logic target;
        logic rd;
        logic eval;
        logic div;
        logic lerp;
        logic publish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic storable;
        logic is_line;
        logic is_final;
        logic count_zero;
        logic hit;
        logic seg_zero;
        logic last;
        logic step_last;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== hw/rtl/polyline_point_at_length.sv =====
// Point, tangent and normal at a fraction of a polyline's arc length.
// Input channel (i_in_valid / o_in_stall): one vertex per request with its
// command (move-to, line-to, other), Q16.16 coordinates and a final flag.
// Output channel (o_out_valid / i_out_stall): one result per final vertex:
// found flag, total length, point, tangent and normal.
// Config channel (i_cfg_valid / o_cfg_ready): path fraction, always ready;
// write it only while the block is idle.
// Each vertex is finished before the next is taken: a line-to vertex
// runs the 33-step digit-by-digit square root of the segment length,
// while a move-to and ignored commands skip it.
// For a final vertex the result follows its own measurement, a walk
// through the single-port vertex store that reads and checks each stored
// vertex, the bit-serial ratio divider, the scaling step and the output register.
// Reset clears the path state, the fraction and the output valid.
// The output register holds a result while i_out_stall is high; new
// vertices are still taken then, and only the next result waits for it.
`timescale 1ns / 1ps
`default_nettype none
module polyline_point_at_length #(
    parameter int MAX_VERTICES  = ppal_pkg::MAX_VERTICES_DEF,
    parameter int FRACTION_BITS = ppal_pkg::FRACTION_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [1:0]             i_vertex_command,
    input  wire  signed [31:0]     i_vertex_x,
    input  wire  signed [31:0]     i_vertex_y,
    input  wire                    i_final_vertex,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [FRACTION_BITS:0] i_cfg_path_fraction,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output logic                   o_found,
    output logic [43:0]            o_total_length,
    output logic signed [31:0]     o_point_x,
    output logic signed [31:0]     o_point_y,
    output logic signed [32:0]     o_tangent_x,
    output logic signed [32:0]     o_tangent_y,
    output logic signed [32:0]     o_normal_x,
    output logic signed [32:0]     o_normal_y
);

    ppal_pkg::t_dp_cmd    w_cmd;
    ppal_pkg::t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ppal_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ppal_dp #(
        .MAX_VERTICES  (MAX_VERTICES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_vertex_command    (i_vertex_command),
        .i_vertex_x          (i_vertex_x),
        .i_vertex_y          (i_vertex_y),
        .i_final_vertex      (i_final_vertex),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_path_fraction (i_cfg_path_fraction),
        .i_out_stall         (i_out_stall),
        .o_out_valid         (o_out_valid),
        .o_found             (o_found),
        .o_total_length      (o_total_length),
        .o_point_x           (o_point_x),
        .o_point_y           (o_point_y),
        .o_tangent_x         (o_tangent_x),
        .o_tangent_y         (o_tangent_y),
        .o_normal_x          (o_normal_x),
        .o_normal_y          (o_normal_y)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/ppal_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ppal_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  ppal_pkg::t_dp_status i_status,
    output ppal_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_DIFF   = 12'b0000_0000_0010,
        ST_SQR    = 12'b0000_0000_0100,
        ST_SUM    = 12'b0000_0000_1000,
        ST_ROOT   = 12'b0000_0001_0000,
        ST_STORE  = 12'b0000_0010_0000,
        ST_TARGET = 12'b0000_0100_0000,
        ST_RD     = 12'b0000_1000_0000,
        ST_EVAL   = 12'b0001_0000_0000,
        ST_DIV    = 12'b0010_0000_0000,
        ST_LERP   = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // Sequence the vertex measurement and the final walk
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                if (!i_status.storable) begin
                    n_state = i_status.is_final ? ST_TARGET : ST_IDLE;
                end else if (i_status.is_line) begin
                    n_state = ST_SQR;
                end else begin
                    n_state = ST_STORE;
                end
            end
            ST_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root = 1'b1;
                if (i_status.step_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_status.is_final ? ST_TARGET : ST_IDLE;
            end
            ST_TARGET: begin
                o_cmd.target = 1'b1;
                n_state      = i_status.count_zero ? ST_DONE : ST_RD;
            end
            ST_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EVAL;
            end
            ST_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_status.hit) begin
                    n_state = i_status.seg_zero ? ST_LERP : ST_DIV;
                end else if (i_status.last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.step_last) begin
                    n_state = ST_LERP;
                end
            end
            ST_LERP: begin
                o_cmd.lerp = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ppal_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ppal_dp #(
    parameter int MAX_VERTICES  = ppal_pkg::MAX_VERTICES_DEF,
    parameter int FRACTION_BITS = ppal_pkg::FRACTION_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  ppal_pkg::t_dp_cmd            i_cmd,
    output ppal_pkg::t_dp_status         o_status,
    input  wire  [1:0]                   i_vertex_command,
    input  wire  signed [31:0]           i_vertex_x,
    input  wire  signed [31:0]           i_vertex_y,
    input  wire                          i_final_vertex,
    input  wire                          i_cfg_valid,
    input  wire  [FRACTION_BITS:0]       i_cfg_path_fraction,
    input  wire                          i_out_stall,
    output logic                         o_out_valid,
    output logic                         o_found,
    output logic [43:0]                  o_total_length,
    output logic signed [31:0]           o_point_x,
    output logic signed [31:0]           o_point_y,
    output logic signed [32:0]           o_tangent_x,
    output logic signed [32:0]           o_tangent_y,
    output logic signed [32:0]           o_normal_x,
    output logic signed [32:0]           o_normal_y
);

    localparam int CW = ppal_pkg::COORD_W;
    localparam int DW = ppal_pkg::DIFF_W;
    localparam int SW = ppal_pkg::SEG_W;
    localparam int LW = ppal_pkg::LEN_W;
    localparam int RW = ppal_pkg::ROOT_W;
    localparam int QW = ppal_pkg::RATIO_W;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int MW = 1 + SW + 2 * CW;
    localparam int TW = LW + 2;
    localparam int PW = DW + QW;
    localparam logic [NW-1:0] MAX_CNT = NW'(MAX_VERTICES);

    // Vertex store: {is_move, segment length, y, x}
    logic [MW-1:0] r_mem [MAX_VERTICES];
    logic [MW-1:0] r_rd;

    // Captured request and path state
    logic [1:0]          r_cmd;
    logic signed [CW-1:0] r_x, r_y, r_cur_x, r_cur_y;
    logic                r_fin;
    logic [NW-1:0]       r_count;
    logic [LW-1:0]       r_run;
    logic [FRACTION_BITS:0] r_frac;

    // Length unit
    logic [DW-1:0]       r_mag_x, r_mag_y;
    logic [2*DW-1:0]     r_sq_x, r_sq_y;
    logic [ppal_pkg::RAD_W-1:0] r_rad;
    logic [RW+1:0]       r_rem;
    logic [RW-1:0]       r_root;
    logic [ppal_pkg::STEP_W-1:0] r_step;

    // Walk and interpolation
    logic [TW-1:0]       r_target;
    logic [AW-1:0]       r_idx;
    logic [LW-1:0]       r_acc;
    logic signed [CW-1:0] r_px, r_py;
    logic                r_found;
    logic signed [DW-1:0] r_dx, r_dy;
    logic [SW-1:0]       r_seg;
    logic [SW:0]         r_dr;
    logic [QW-1:0]       r_q;
    logic [PW-1:0]       r_prod_x, r_prod_y;

    // Difference to the current point
    logic signed [DW-1:0] w_dx, w_dy;
    assign w_dx = {r_x[CW-1], r_x} - {r_cur_x[CW-1], r_cur_x};
    assign w_dy = {r_y[CW-1], r_y} - {r_cur_y[CW-1], r_cur_y};

    // One root digit
    logic [RW+3:0] w_nrem, w_trial;
    assign w_nrem  = {r_rem, r_rad[ppal_pkg::RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};

    // Saturating sums
    logic [LW:0]   w_run_sum, w_acc_sum;
    logic [LW-1:0] w_run_sat, w_nacc;
    assign w_run_sum = {1'b0, r_run} + (LW + 1)'(r_root);
    assign w_run_sat = w_run_sum[LW] ? '1 : w_run_sum[LW-1:0];

    // Fields of the read entry
    logic                 w_rd_move;
    logic [SW-1:0]        w_rd_seg;
    logic signed [CW-1:0] w_rd_x, w_rd_y;
    assign w_rd_move = r_rd[MW-1];
    assign w_rd_seg  = r_rd[2*CW +: SW];
    assign w_rd_y    = r_rd[CW +: CW];
    assign w_rd_x    = r_rd[0 +: CW];
    assign w_acc_sum = {1'b0, r_acc} + (LW + 1)'(w_rd_seg);
    assign w_nacc    = w_acc_sum[LW] ? '1 : w_acc_sum[LW-1:0];

    // Target = total * fraction, floored
    logic [LW:0]            w_t_hi;
    logic [2*FRACTION_BITS:0] w_t_lo;
    logic [TW-1:0]          w_target;
    assign w_t_hi   = (LW + 1)'(r_run[LW-1:FRACTION_BITS] * r_frac);
    assign w_t_lo   = r_run[FRACTION_BITS-1:0] * r_frac;
    assign w_target = {1'b0, w_t_hi} + TW'(w_t_lo >> FRACTION_BITS);

    // Remainder into the segment, clamped to its length
    logic [TW-1:0] w_rem_raw;
    logic [SW-1:0] w_rem;
    assign w_rem_raw = (r_target > TW'(r_acc)) ? (r_target - TW'(r_acc)) : '0;
    assign w_rem     = (w_rem_raw > TW'(w_rd_seg)) ? w_rd_seg : SW'(w_rem_raw);

    logic w_hit;
    assign w_hit = !w_rd_move && (TW'(w_nacc) >= r_target);

    // One quotient bit
    logic [SW:0] w_dt;
    assign w_dt = (r_step == ppal_pkg::DIV_STEPS) ? r_dr : {r_dr[SW-1:0], 1'b0};

    // Magnitudes of the segment vector
    logic [DW-1:0] w_mdx, w_mdy;
    assign w_mdx = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
    assign w_mdy = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);

    // Round the offsets and add to the segment start
    logic [PW:0]     w_rx, w_ry;
    logic [DW:0]     w_ox, w_oy;
    logic [DW+1:0]   w_ptx, w_pty;
    assign w_rx  = {1'b0, r_prod_x} + (PW + 1)'(1 << (ppal_pkg::RATIO_BITS - 1));
    assign w_ry  = {1'b0, r_prod_y} + (PW + 1)'(1 << (ppal_pkg::RATIO_BITS - 1));
    assign w_ox  = (DW + 1)'(w_rx >> ppal_pkg::RATIO_BITS);
    assign w_oy  = (DW + 1)'(w_ry >> ppal_pkg::RATIO_BITS);
    assign w_ptx = {{3{r_px[CW-1]}}, r_px} + (r_dx[DW-1] ? -{1'b0, w_ox} : {1'b0, w_ox});
    assign w_pty = {{3{r_py[CW-1]}}, r_py} + (r_dy[DW-1] ? -{1'b0, w_oy} : {1'b0, w_oy});

    logic w_out_free;
    assign w_out_free = !o_out_valid || !i_out_stall;

    // Status
    always_comb begin
        o_status            = '0;
        o_status.storable   = ((r_cmd == ppal_pkg::CMD_MOVE) || (r_cmd == ppal_pkg::CMD_LINE))
                              && (r_count < MAX_CNT);
        o_status.is_line    = (r_cmd == ppal_pkg::CMD_LINE);
        o_status.is_final   = r_fin;
        o_status.count_zero = (r_count == '0);
        o_status.hit        = w_hit;
        o_status.seg_zero   = (w_rd_seg == '0);
        o_status.last       = (NW'(r_idx) + NW'(1) == r_count);
        o_status.step_last  = (r_step == ppal_pkg::STEP_W'(1));
        o_status.out_free   = w_out_free;
    end

    // Write and read the vertex store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[r_count[AW-1:0]] <= {(r_cmd == ppal_pkg::CMD_MOVE),
                (r_cmd == ppal_pkg::CMD_LINE) ? SW'(r_root) : SW'(0), r_y, r_x};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[r_idx];
        end
    end

    // Control registers: path state, fraction, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_run       <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_frac      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_frac <= i_cfg_path_fraction;
            end
            if (i_cmd.store) begin
                r_count <= r_count + NW'(1);
                r_cur_x <= r_x;
                r_cur_y <= r_y;
                if (r_cmd == ppal_pkg::CMD_LINE) begin
                    r_run <= w_run_sat;
                end
            end
            if (i_cmd.publish) begin
                r_count     <= '0;
                r_run       <= '0;
                r_cur_x     <= '0;
                r_cur_y     <= '0;
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        // Capture the request
        if (i_cmd.cap) begin
            r_cmd <= i_vertex_command;
            r_x   <= i_vertex_x;
            r_y   <= i_vertex_y;
            r_fin <= i_final_vertex;
        end
        // Measure the segment
        if (i_cmd.diff) begin
            r_mag_x <= w_dx[DW-1] ? DW'(-w_dx) : DW'(w_dx);
            r_mag_y <= w_dy[DW-1] ? DW'(-w_dy) : DW'(w_dy);
            r_root  <= '0;
        end
        if (i_cmd.sqr) begin
            r_sq_x <= r_mag_x * r_mag_x;
            r_sq_y <= r_mag_y * r_mag_y;
        end
        if (i_cmd.sum) begin
            r_rad  <= r_sq_x + r_sq_y;
            r_rem  <= '0;
            r_root <= '0;
            r_step <= ppal_pkg::ROOT_STEPS;
        end
        if (i_cmd.root) begin
            r_rad  <= {r_rad[ppal_pkg::RAD_W-3:0], 2'b00};
            r_step <= r_step - ppal_pkg::STEP_W'(1);
            if (w_nrem >= w_trial) begin
                r_rem  <= (RW + 2)'(w_nrem - w_trial);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= (RW + 2)'(w_nrem);
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
        // Start the walk
        if (i_cmd.target) begin
            r_target <= w_target;
            r_idx    <= '0;
            r_acc    <= '0;
            r_px     <= '0;
            r_py     <= '0;
            r_found  <= 1'b0;
            r_q      <= '0;
        end
        // Evaluate one stored vertex
        if (i_cmd.eval) begin
            if (w_rd_move) begin
                r_px  <= w_rd_x;
                r_py  <= w_rd_y;
                r_idx <= r_idx + AW'(1);
            end else if (w_hit) begin
                r_found <= 1'b1;
                r_dx    <= {w_rd_x[CW-1], w_rd_x} - {r_px[CW-1], r_px};
                r_dy    <= {w_rd_y[CW-1], w_rd_y} - {r_py[CW-1], r_py};
                r_seg   <= w_rd_seg;
                r_dr    <= {1'b0, w_rem};
                r_q     <= '0;
                r_step  <= ppal_pkg::DIV_STEPS;
            end else begin
                r_acc <= w_nacc;
                r_px  <= w_rd_x;
                r_py  <= w_rd_y;
                r_idx <= r_idx + AW'(1);
            end
        end
        // Produce one ratio bit
        if (i_cmd.div) begin
            r_step <= r_step - ppal_pkg::STEP_W'(1);
            if (w_dt >= {1'b0, r_seg}) begin
                r_dr <= w_dt - {1'b0, r_seg};
                r_q  <= {r_q[QW-2:0], 1'b1};
            end else begin
                r_dr <= w_dt;
                r_q  <= {r_q[QW-2:0], 1'b0};
            end
        end
        // Scale the segment vector
        if (i_cmd.lerp) begin
            r_prod_x <= w_mdx * r_q;
            r_prod_y <= w_mdy * r_q;
        end
        // Load the result
        if (i_cmd.publish) begin
            o_found        <= r_found;
            o_total_length <= r_run;
            o_point_x      <= r_found ? w_ptx[CW-1:0] : '0;
            o_point_y      <= r_found ? w_pty[CW-1:0] : '0;
            o_tangent_x    <= r_found ? r_dx : '0;
            o_tangent_y    <= r_found ? r_dy : '0;
            o_normal_x     <= r_found ? r_dy : '0;
            o_normal_y     <= r_found ? -r_dx : '0;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/ppal_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ppal_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_stall,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire               o_found,
    input wire signed [31:0] o_point_x,
    input wire signed [31:0] o_point_y,
    input wire signed [32:0] o_tangent_x,
    input wire signed [32:0] o_tangent_y,
    input wire signed [32:0] o_normal_x,
    input wire signed [32:0] o_normal_y
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Stall after every accepted request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("no stall after accepted request");

    // Normal is the rotated tangent
    a_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_normal_x == o_tangent_y) && (o_normal_y == 33'(-o_tangent_x)))
        else $error("normal does not match tangent");

    // Zero geometry when nothing was found
    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_point_x == 0) && (o_point_y == 0)
            && (o_tangent_x == 0) && (o_tangent_y == 0))
        else $error("geometry set on not-found result");

endmodule

bind polyline_point_at_length ppal_checker u_ppal_checker (.*);
`default_nettype wire
